[hdl/text_input_validator_top_defines.svh]
// assertion macros for the text input validator
`ifndef TEXT_INPUT_VALIDATOR_TOP_DEFINES_SVH
`define TEXT_INPUT_VALIDATOR_TOP_DEFINES_SVH

`ifndef SYNTH
// check a property on clk, off while arst_n is low
`define TIV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check that cond holds whenever trig holds
`define TIV_ASSERT_IMPL(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);
`else
`define TIV_ASSERT(lbl, prop, msg)
`define TIV_ASSERT_IMPL(lbl, trig, cond, msg)
`endif

`endif

[hdl/tiv_pkg.sv]
package tiv_pkg;

	localparam int CountBitsDefault = 24;
	localparam int CfgW = 24;
	localparam logic [CfgW-1:0] LimitReset = 24'd1048576;

	localparam logic [7:0] CharLt = 8'h3C;
	localparam logic [7:0] CharGt = 8'h3E;
	localparam logic [7:0] CharSlash = 8'h2F;
	localparam logic [7:0] CharQuest = 8'h3F;
	localparam logic [7:0] CharBang = 8'h21;

	localparam int DeclLen = 5;
	localparam int BpmnLen = 5;
	localparam int ProcLen = 8;

	localparam logic [7:0] MarkDecl [DeclLen] = '{8'h3C, 8'h3F, 8'h78, 8'h6D, 8'h6C};
	localparam logic [7:0] MarkBpmn [BpmnLen] = '{8'h3C, 8'h62, 8'h70, 8'h6D, 8'h6E};
	localparam logic [7:0] MarkProc [ProcLen] =
		'{8'h3C, 8'h70, 8'h72, 8'h6F, 8'h63, 8'h65, 8'h73, 8'h73};

	typedef enum logic [2:0] {
		StatusOk       = 3'd0,
		StatusEmpty    = 3'd1,
		StatusTooLarge = 3'd2,
		StatusBadText  = 3'd3,
		StatusTruncXml = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KindNone      = 2'd0,
		KindMalformed = 2'd1,
		KindResource  = 2'd2
	} kind_t;

endpackage

[hdl/text_input_validator_top.sv]
// channel   | beat fields (lowest bit first)                  | handshake
// ----------+-------------------------------------------------+--------------------------
// s_axis    | tdata: data_byte; tuser: byte_valid; tlast      | s_axis_tvalid/tready
// m_axis    | tdata: status (zero padded); tuser: incident    | m_axis_tvalid/tready
// cfg       | cfg_data: max_input_bytes                       | cfg_valid/cfg_ready
//
// one byte per clock sustained while no closing beat waits; the closing beat is held in the
// input register and the status is loaded into the result register once that register is
// free, and m_axis_tvalid rises as the status is loaded.
// arst_n clears all message state and loads the size limit with 1048576.
// a stalled result holds in the result register while bytes keep flowing; only a
// closing beat waits in the input register until the result register frees.
// cfg_ready is always high; the limit is applied to the next closing beat.
`include "text_input_validator_top_defines.svh"

module text_input_validator_top
	import tiv_pkg::*;
#(
	parameter int COUNT_BITS = CountBitsDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [7:0]      s_axis_tdata,  // [7:0] data_byte
	input  logic            s_axis_tlast,  // last_byte
	input  logic [0:0]      s_axis_tuser,  // [0] byte_valid
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [2:0] status, [7:3] zero
	output logic [1:0]      m_axis_tuser,  // [1:0] incident_kind
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [CfgW-1:0] cfg_data
);

	localparam int TotalW = COUNT_BITS + 1;

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        bvalid_s1;
	logic        last_s1;
	logic        go;

	// message state
	logic [COUNT_BITS-1:0] limit_q;
	logic [TotalW-1:0]     byte_total_q, byte_total_d;
	logic [1:0]            cont_pend_q, cont_pend_d;
	logic                  enc_err_q, enc_err_d;
	logic [2:0]            m_decl_q, m_decl_d;
	logic [2:0]            m_bpmn_q, m_bpmn_d;
	logic [2:0]            m_proc_q, m_proc_d;
	logic                  marker_q, marker_d;
	logic                  in_tag_q, in_tag_d;
	logic [1:0]            tag_len_q, tag_len_d;
	logic                  closing_q, closing_d;
	logic                  skipped_q, skipped_d;
	logic [7:0]            prev_q, prev_d;
	logic [TotalW-1:0]     balance_q, balance_d;

	status_t status_d;
	kind_t   kind_d;

	assign cfg_ready = 1'b1;
	assign go = valid_s1 && (!last_s1 || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1   <= s_axis_tdata;
			bvalid_s1 <= s_axis_tuser[0];
			last_s1   <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= COUNT_BITS'(LimitReset);
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= COUNT_BITS'(cfg_data);
		end
	end

	always_comb begin
		logic [7:0] b;
		logic [3:0] nd;
		logic       hit;
		b            = data_s1;
		byte_total_d = byte_total_q;
		cont_pend_d  = cont_pend_q;
		enc_err_d    = enc_err_q;
		m_decl_d     = m_decl_q;
		m_bpmn_d     = m_bpmn_q;
		m_proc_d     = m_proc_q;
		marker_d     = marker_q;
		in_tag_d     = in_tag_q;
		tag_len_d    = tag_len_q;
		closing_d    = closing_q;
		skipped_d    = skipped_q;
		prev_d       = prev_q;
		balance_d    = balance_q;
		hit          = 1'b0;
		nd           = '0;

		if (bvalid_s1) begin
			if (byte_total_q != '1) begin
				byte_total_d = byte_total_q + TotalW'(1);
			end

			// loose utf-8 and control bytes
			if (!enc_err_q) begin
				if (cont_pend_q != 2'd0) begin
					if (b[7:6] == 2'b10) begin
						cont_pend_d = cont_pend_q - 2'd1;
					end else begin
						enc_err_d = 1'b1;
					end
				end else if (!b[7]) begin
					enc_err_d = b inside {[8'h00:8'h08], [8'h0E:8'h1F], 8'h7F};
				end else if (b[7:5] == 3'b110) begin
					cont_pend_d = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					cont_pend_d = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					cont_pend_d = 2'd3;
				end else begin
					enc_err_d = 1'b1;
				end
			end

			// marker matchers; a mismatch on '<' restarts at one
			if (b == MarkDecl[m_decl_q]) begin
				nd = {1'b0, m_decl_q} + 4'd1;
				if (nd == 4'(DeclLen)) begin
					hit      = 1'b1;
					m_decl_d = '0;
				end else begin
					m_decl_d = nd[2:0];
				end
			end else begin
				m_decl_d = {2'b00, b == CharLt};
			end
			if (b == MarkBpmn[m_bpmn_q]) begin
				nd = {1'b0, m_bpmn_q} + 4'd1;
				if (nd == 4'(BpmnLen)) begin
					hit      = 1'b1;
					m_bpmn_d = '0;
				end else begin
					m_bpmn_d = nd[2:0];
				end
			end else begin
				m_bpmn_d = {2'b00, b == CharLt};
			end
			if (b == MarkProc[m_proc_q]) begin
				nd = {1'b0, m_proc_q} + 4'd1;
				if (nd == 4'(ProcLen)) begin
					hit      = 1'b1;
					m_proc_d = '0;
				end else begin
					m_proc_d = nd[2:0];
				end
			end else begin
				m_proc_d = {2'b00, b == CharLt};
			end
			marker_d = marker_q || hit;

			// tag balance
			if (!in_tag_q) begin
				if (b == CharLt) begin
					in_tag_d  = 1'b1;
					tag_len_d = 2'd1;
					closing_d = 1'b0;
					skipped_d = 1'b0;
				end
			end else begin
				if (prev_q == CharLt && (b == CharQuest || b == CharBang)) begin
					skipped_d = 1'b1;
				end
				if (tag_len_q == 2'd1 && b == CharSlash) begin
					closing_d = 1'b1;
				end
				if (b == CharGt) begin
					if (!skipped_d) begin
						if (closing_d) begin
							balance_d = balance_q - TotalW'(1);
						end else if (prev_q != CharSlash) begin
							balance_d = balance_q + TotalW'(1);
						end
					end
					in_tag_d  = 1'b0;
					tag_len_d = 2'd0;
					closing_d = 1'b0;
					skipped_d = 1'b0;
				end else if (tag_len_q != 2'd3) begin
					tag_len_d = tag_len_q + 2'd1;
				end
			end
			prev_d = b;
		end

		if (byte_total_d == '0) begin
			status_d = StatusEmpty;
		end else if (byte_total_d > {1'b0, limit_q}) begin
			status_d = StatusTooLarge;
		end else if (enc_err_d || cont_pend_d != 2'd0) begin
			status_d = StatusBadText;
		end else if (marker_d && balance_d != '0) begin
			status_d = StatusTruncXml;
		end else begin
			status_d = StatusOk;
		end

		case (status_d)
			StatusOk:       kind_d = KindNone;
			StatusTooLarge: kind_d = KindResource;
			default:        kind_d = KindMalformed;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_total_q <= '0;
			cont_pend_q  <= '0;
			enc_err_q    <= 1'b0;
			m_decl_q     <= '0;
			m_bpmn_q     <= '0;
			m_proc_q     <= '0;
			marker_q     <= 1'b0;
			in_tag_q     <= 1'b0;
			tag_len_q    <= '0;
			closing_q    <= 1'b0;
			skipped_q    <= 1'b0;
			prev_q       <= '0;
			balance_q    <= '0;
		end else if (go) begin
			if (last_s1) begin
				// message done, start clean
				byte_total_q <= '0;
				cont_pend_q  <= '0;
				enc_err_q    <= 1'b0;
				m_decl_q     <= '0;
				m_bpmn_q     <= '0;
				m_proc_q     <= '0;
				marker_q     <= 1'b0;
				in_tag_q     <= 1'b0;
				tag_len_q    <= '0;
				closing_q    <= 1'b0;
				skipped_q    <= 1'b0;
				prev_q       <= '0;
				balance_q    <= '0;
			end else begin
				byte_total_q <= byte_total_d;
				cont_pend_q  <= cont_pend_d;
				enc_err_q    <= enc_err_d;
				m_decl_q     <= m_decl_d;
				m_bpmn_q     <= m_bpmn_d;
				m_proc_q     <= m_proc_d;
				marker_q     <= marker_d;
				in_tag_q     <= in_tag_d;
				tag_len_q    <= tag_len_d;
				closing_q    <= closing_d;
				skipped_q    <= skipped_d;
				prev_q       <= prev_d;
				balance_q    <= balance_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (go && last_s1) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			m_axis_tdata <= {5'b00000, status_d};
			m_axis_tuser <= kind_d;
		end
	end

	`TIV_ASSERT(a_clear_after_end, (go && last_s1) |=> (byte_total_q == '0 && !in_tag_q), "message state not cleared after closing beat")
	`TIV_ASSERT_IMPL(a_err_needs_bytes, enc_err_q, byte_total_q != '0, "encoding error with no bytes counted")
	`TIV_ASSERT_IMPL(a_empty_no_tags, byte_total_q == '0, (balance_q == '0 && !marker_q && cont_pend_q == 2'd0), "tag or utf-8 state set before any byte")
	`TIV_ASSERT_IMPL(a_end_waits, (valid_s1 && last_s1 && m_axis_tvalid && !m_axis_tready), !s_axis_tready, "input taken while closing beat is stalled")

endmodule
